// ----- sv/bsc_pkg.sv -----
// Shared constants and types for the bit map store with cursor clear.
package bsc_pkg;

    localparam int NUM_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = NUM_BITS / WORD_BITS;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);

    localparam int MODE_W = 3;
    localparam int IDX_W  = 10;
    localparam int CUR_W  = 11;
    localparam int SIZE_W = 11;

    localparam logic [SIZE_W-1:0]    SIZE_RESET   = SIZE_W'(1024);
    localparam logic [CUR_W-1:0]     CURSOR_RESET = {CUR_W{1'b1}};
    localparam logic [WORD_BITS-1:0] WORD_ONES    = {WORD_BITS{1'b1}};
    localparam logic [WADDR_W-1:0]   LAST_WORD    = WADDR_W'(NUM_WORDS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE     = 3'd0,
        MODE_TEST_CLR  = 3'd1,
        MODE_CLR_NEXT  = 3'd2,
        MODE_FILL      = 3'd3,
        MODE_CLEAR_ALL = 3'd4,
        MODE_READ      = 3'd5,
        MODE_SCAN      = 3'd6
    } t_mode;

endpackage

// ----- sv/bsc_if.sv -----
// Handshake channels: item input, result output and size register write.
interface bsc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bsc_pkg::MODE_W-1:0] mode;
    logic [bsc_pkg::IDX_W-1:0]  bit_index;
    logic                       write_value;

    modport source (output valid, mode, bit_index, write_value, input ready);
    modport sink   (input valid, mode, bit_index, write_value, output ready);
endinterface

interface bsc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      bit_out;
    logic [bsc_pkg::IDX_W-1:0] first_index;
    logic                      found;
    logic                      all_clear;

    modport source (output valid, bit_out, first_index, found, all_clear, input ready);
    modport sink   (input valid, bit_out, first_index, found, all_clear, output ready);
endinterface

interface bsc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bsc_pkg::SIZE_W-1:0] bits_in_use;

    modport source (output valid, bits_in_use, input ready);
    modport sink   (input valid, bits_in_use, output ready);
endinterface

// ----- sv/bitmap_store_with_cursor_clear.sv -----
// Bit map store with a clearing cursor and a lowest-set-bit scan.
// The map lives in a word memory with one read and one write port; single-bit modes
// (write, test-and-clear, clear next, read) read one word and, but for read, write it back
// modified, through a read state and a write state, or skip both when the index lies
// beyond the map. Fill and clear all act on per-word valid bits plus a fill flag.
// Scan walks the memory one word a cycle through a find-first-set unit. The input is
// ready only while the block is idle; a result sits in an output register and the next
// word is accepted while it waits. The size register may be written at any time the
// block is idle.
module bitmap_store_with_cursor_clear (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsc_in_if.sink    i_in,
    bsc_out_if.source o_out,
    bsc_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [bsc_pkg::MODE_W-1:0]      r_mode, n_mode;
    logic                            r_wv, n_wv;
    logic [bsc_pkg::CUR_W-1:0]       r_tgt, n_tgt;
    logic [bsc_pkg::CUR_W-1:0]       r_cursor, n_cursor;
    logic [bsc_pkg::NUM_WORDS-1:0]   r_valid, n_valid;
    logic                            r_fill, n_fill;
    logic [bsc_pkg::WADDR_W-1:0]     r_addr, n_addr;
    logic                            r_rd_vld, n_rd_vld;
    logic                            r_pv, n_pv;
    logic [bsc_pkg::WADDR_W-1:0]     r_pw, n_pw;
    logic                            r_issued, n_issued;
    logic                            r_found, n_found;
    logic [bsc_pkg::IDX_W-1:0]       r_first, n_first;
    logic [bsc_pkg::WORD_BITS-1:0]   r_acc, n_acc;
    logic                            r_res_bit, n_res_bit;
    logic                            r_res_clear, n_res_clear;
    logic [bsc_pkg::SIZE_W-1:0]      r_bits_in_use, n_bits_in_use;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_bit, n_out_bit;
    logic [bsc_pkg::IDX_W-1:0]       r_out_first, n_out_first;
    logic                            r_out_found, n_out_found;
    logic                            r_out_clear, n_out_clear;

    logic [bsc_pkg::WORD_BITS-1:0]   r_mem [bsc_pkg::NUM_WORDS];
    logic [bsc_pkg::WORD_BITS-1:0]   r_rd_data;
    logic                            mem_we;
    logic [bsc_pkg::WORD_BITS-1:0]   mem_wdata;

    logic                            in_acc;
    logic                            can_put;
    logic [bsc_pkg::CUR_W-1:0]       new_tgt;
    logic                            new_tgt_ok;
    logic [31:0]                     new_tgt_w;
    logic [31:0]                     tgt_w;
    logic [bsc_pkg::OFF_W-1:0]       tgt_off;
    logic [bsc_pkg::WORD_BITS-1:0]   eff_word;
    logic [bsc_pkg::WORD_BITS-1:0]   mod_word;
    logic [31:0]                     scan_base;
    logic [31:0]                     scan_lim;
    logic [31:0]                     scan_diff;
    logic [bsc_pkg::WORD_BITS-1:0]   scan_mask;
    logic [bsc_pkg::WORD_BITS-1:0]   scan_masked;
    logic [bsc_pkg::OFF_W-1:0]       scan_pos;
    logic [bsc_pkg::WORD_BITS-1:0]   acc_next;

    // Lowest set bit of a word by halving the window; caller checks for zero.
    function automatic logic [bsc_pkg::OFF_W-1:0] ffs_pos(
        input logic [bsc_pkg::WORD_BITS-1:0] w
    );
        logic [bsc_pkg::WORD_BITS-1:0] v;
        logic [bsc_pkg::OFF_W-1:0]     pos;
        v   = w;
        pos = '0;
        for (int s = bsc_pkg::OFF_W - 1; s >= 0; s--) begin
            if ((v & ~(bsc_pkg::WORD_ONES << (1 << s))) == '0) begin
                v      = v >> (1 << s);
                pos[s] = 1'b1;
            end
        end
        return pos;
    endfunction

    assign in_acc       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign can_put      = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.bit_out     = r_out_bit;
    assign o_out.first_index = r_out_first;
    assign o_out.found       = r_out_found;
    assign o_out.all_clear   = r_out_clear;

    // Words never written since fill or clear read as the fill value.
    assign eff_word = r_rd_vld ? r_rd_data : {bsc_pkg::WORD_BITS{r_fill}};

    assign tgt_w   = 32'(r_tgt);
    assign tgt_off = tgt_w[bsc_pkg::OFF_W-1:0];

    always_comb begin
        mod_word          = eff_word;
        mod_word[tgt_off] = (bsc_pkg::t_mode'(r_mode) == bsc_pkg::MODE_WRITE) ? r_wv : 1'b0;
    end

    // Scan window for the word under test.
    assign scan_base = 32'({r_pw, {bsc_pkg::OFF_W{1'b0}}});
    assign scan_lim  = (32'(r_bits_in_use) > 32'(bsc_pkg::NUM_BITS)) ?
                       32'(bsc_pkg::NUM_BITS) : 32'(r_bits_in_use);
    assign scan_diff = scan_lim - scan_base;

    always_comb begin
        if (scan_lim >= scan_base + 32'(bsc_pkg::WORD_BITS)) begin
            scan_mask = bsc_pkg::WORD_ONES;
        end else if (scan_lim <= scan_base) begin
            scan_mask = '0;
        end else begin
            scan_mask = ~(bsc_pkg::WORD_ONES << scan_diff[bsc_pkg::OFF_W-1:0]);
        end
    end

    assign scan_masked = eff_word & scan_mask;
    assign scan_pos    = ffs_pos(scan_masked);
    assign acc_next    = r_acc | eff_word;

    always_comb begin
        case (bsc_pkg::t_mode'(i_in.mode))
            bsc_pkg::MODE_TEST_CLR: new_tgt = {1'b0, i_in.bit_index};
            bsc_pkg::MODE_CLR_NEXT: new_tgt = r_cursor + bsc_pkg::CUR_W'(1);
            default:                new_tgt = {1'b0, i_in.bit_index};
        endcase
    end
    assign new_tgt_w  = 32'(new_tgt);
    assign new_tgt_ok = (new_tgt_w < 32'(bsc_pkg::NUM_BITS));

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_wv          = r_wv;
        n_tgt         = r_tgt;
        n_cursor      = r_cursor;
        n_valid       = r_valid;
        n_fill        = r_fill;
        n_addr        = r_addr;
        n_rd_vld      = r_valid[r_addr];
        n_pv          = r_pv;
        n_pw          = r_pw;
        n_issued      = r_issued;
        n_found       = r_found;
        n_first       = r_first;
        n_acc         = r_acc;
        n_res_bit     = r_res_bit;
        n_res_clear   = r_res_clear;
        n_bits_in_use = r_bits_in_use;
        n_out_valid   = r_out_valid;
        n_out_bit     = r_out_bit;
        n_out_first   = r_out_first;
        n_out_found   = r_out_found;
        n_out_clear   = r_out_clear;
        mem_we        = 1'b0;
        mem_wdata     = mod_word;

        if (i_cfg.valid) begin
            n_bits_in_use = i_cfg.bits_in_use;
        end

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode      = i_in.mode;
                    n_wv        = i_in.write_value;
                    n_tgt       = new_tgt;
                    n_res_bit   = 1'b0;
                    n_res_clear = 1'b0;
                    n_found     = 1'b0;
                    n_first     = '0;
                    n_state     = S_DONE;
                    case (bsc_pkg::t_mode'(i_in.mode))
                        bsc_pkg::MODE_WRITE, bsc_pkg::MODE_READ,
                        bsc_pkg::MODE_TEST_CLR, bsc_pkg::MODE_CLR_NEXT: begin
                            if (bsc_pkg::t_mode'(i_in.mode) == bsc_pkg::MODE_TEST_CLR ||
                                bsc_pkg::t_mode'(i_in.mode) == bsc_pkg::MODE_CLR_NEXT) begin
                                n_cursor = new_tgt;
                            end
                            // Out-of-map targets read as zero and write nothing.
                            if (new_tgt_ok) begin
                                n_addr  = new_tgt_w[bsc_pkg::OFF_W +: bsc_pkg::WADDR_W];
                                n_state = S_RD;
                            end
                        end
                        bsc_pkg::MODE_FILL: begin
                            n_valid  = '0;
                            n_fill   = 1'b1;
                            n_cursor = bsc_pkg::CURSOR_RESET;
                        end
                        bsc_pkg::MODE_CLEAR_ALL: begin
                            n_valid = '0;
                            n_fill  = 1'b0;
                        end
                        bsc_pkg::MODE_SCAN: begin
                            n_addr   = '0;
                            n_pv     = 1'b0;
                            n_issued = 1'b0;
                            n_acc    = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                case (bsc_pkg::t_mode'(r_mode))
                    bsc_pkg::MODE_READ: begin
                        n_res_bit = eff_word[tgt_off];
                    end
                    bsc_pkg::MODE_TEST_CLR: begin
                        n_res_bit        = eff_word[tgt_off];
                        mem_we           = 1'b1;
                        n_valid[r_addr]  = 1'b1;
                    end
                    default: begin
                        mem_we           = 1'b1;
                        n_valid[r_addr]  = 1'b1;
                    end
                endcase
                n_state = S_DONE;
            end
            S_SCAN: begin
                // Issue one word read a cycle; consume the word read the cycle before.
                if (!r_issued) begin
                    n_pw   = r_addr;
                    n_pv   = 1'b1;
                    n_addr = r_addr + bsc_pkg::WADDR_W'(1);
                    if (r_addr == bsc_pkg::LAST_WORD) begin
                        n_issued = 1'b1;
                    end
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    n_acc = acc_next;
                    if (!r_found && scan_masked != '0) begin
                        n_found = 1'b1;
                        n_first = bsc_pkg::IDX_W'(scan_base + 32'(scan_pos));
                    end
                    if (r_pw == bsc_pkg::LAST_WORD) begin
                        n_res_clear = (acc_next == '0);
                        n_pv        = 1'b0;
                        n_state     = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res_bit;
                    n_out_first = r_first;
                    n_out_found = r_found;
                    n_out_clear = r_res_clear;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cursor      <= bsc_pkg::CURSOR_RESET;
            r_valid       <= '0;
            r_fill        <= 1'b0;
            r_pv          <= 1'b0;
            r_issued      <= 1'b0;
            r_bits_in_use <= bsc_pkg::SIZE_RESET;
            r_out_valid   <= 1'b0;
            r_addr        <= '0;
        end else begin
            r_state       <= n_state;
            r_cursor      <= n_cursor;
            r_valid       <= n_valid;
            r_fill        <= n_fill;
            r_pv          <= n_pv;
            r_issued      <= n_issued;
            r_bits_in_use <= n_bits_in_use;
            r_out_valid   <= n_out_valid;
            r_addr        <= n_addr;
        end
        r_mode      <= n_mode;
        r_wv        <= n_wv;
        r_tgt       <= n_tgt;
        r_rd_vld    <= n_rd_vld;
        r_pw        <= n_pw;
        r_found     <= n_found;
        r_first     <= n_first;
        r_acc       <= n_acc;
        r_res_bit   <= n_res_bit;
        r_res_clear <= n_res_clear;
        r_out_bit   <= n_out_bit;
        r_out_first <= n_out_first;
        r_out_found <= n_out_found;
        r_out_clear <= n_out_clear;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input still ready after a word was accepted");

    a_found_not_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> !r_res_clear)
        else $error("scan reports a set bit and an all-clear map together");

    a_cursor_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_cursor)) |-> $past(in_acc))
        else $error("cursor moved without an accepted word");

    a_scan_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_SCAN))
        else $error("scan read pending outside of a scan");

    a_write_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (tgt_w < 32'(bsc_pkg::NUM_BITS)))
        else $error("memory write for an index beyond the map");

endmodule
